// ===== sv/median3_adaptive_ema_filter_defines.svh =====
// Assertion macros used by the checker file of the median/EMA filter.
`ifndef MEDIAN3_ADAPTIVE_EMA_FILTER_DEFINES_SVH
`define MEDIAN3_ADAPTIVE_EMA_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mae_pkg.sv =====
// Types, constants and helper functions of the median/EMA distance filter.
package mae_pkg;

  typedef logic [14:0] echo_t;
  typedef logic [17:0] dist_t;
  typedef logic [8:0]  gain_t;
  typedef logic [7:0]  limit_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_JUMP_LIMIT = 2'd0,
    CFG_FAST_GAIN  = 2'd1,
    CFG_SLOW_GAIN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    limit_t jump_limit_cm;
    gain_t  fast_gain;
    gain_t  slow_gain;
  } mae_cfg_t;

  // Reset values of the configuration registers
  localparam limit_t JUMP_LIMIT_RST = 8'd1;
  localparam gain_t  FAST_GAIN_RST  = 9'd179;
  localparam gain_t  SLOW_GAIN_RST  = 9'd26;

  // Distance above this many whole centimetres reads as no echo
  localparam logic [9:0] MAX_RANGE_CM = 10'd400;

  // echo_us * 4559 / 1024 approximates echo_us / 57.5 in Q.8 centimetres
  localparam logic [12:0] CONV_MUL = 13'd4559;

  // One in Q.8
  localparam gain_t Q_ONE = 9'd256;

  function automatic dist_t median3(input dist_t a, input dist_t b, input dist_t c);
    dist_t lo;
    dist_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  function automatic gain_t sat_gain(input gain_t g);
    return (g > Q_ONE) ? Q_ONE : g;
  endfunction

endpackage

// ===== sv/mae_echo_if.sv =====
// Echo-time channel: valid/ready handshake with one echo duration per transfer.
interface mae_echo_if;
  logic          valid;
  logic          ready;
  mae_pkg::echo_t echo_time_us;

  modport source (output valid, output echo_time_us, input ready);
  modport sink   (input valid, input echo_time_us, output ready);
endinterface

// ===== sv/mae_dist_if.sv =====
// Distance result channel: valid/ready handshake with filtered and median distance.
interface mae_dist_if;
  logic          valid;
  logic          ready;
  mae_pkg::dist_t filtered_distance;
  mae_pkg::dist_t median_distance;

  modport source (output valid, output filtered_distance, output median_distance,
                  input ready);
  modport sink   (input valid, input filtered_distance, input median_distance,
                  output ready);
endinterface

// ===== sv/mae_conv.sv =====
// Input register and echo-time to Q.8 distance conversion stage.
module mae_conv (
  input  logic            clk,
  input  logic            rst,
  mae_echo_if.sink        echo,
  output logic            dist_valid,
  input  logic            dist_ready,
  output mae_pkg::dist_t  distance
);

  logic           echo_valid;
  mae_pkg::echo_t echo_time;
  logic           s1_en;
  logic           s2_en;
  logic [27:0]    product;
  mae_pkg::dist_t raw_dist;
  mae_pkg::dist_t dist_next;

  // Advance a stage when it is empty or its successor takes its item
  assign s2_en      = !dist_valid || dist_ready;
  assign s1_en      = !echo_valid || s2_en;
  assign echo.ready = s1_en;

  // Capture the echo time on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_valid <= 1'b0;
    end else if (s1_en) begin
      echo_valid <= echo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && echo.valid) begin
      echo_time <= echo.echo_time_us;
    end
  end

  // Scale to Q.8 centimetres; drop readings beyond range
  always_comb begin
    product   = 28'(echo_time) * 28'(mae_pkg::CONV_MUL);
    raw_dist  = product[27:10];
    dist_next = (raw_dist[17:8] > mae_pkg::MAX_RANGE_CM) ? '0 : raw_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (s2_en) begin
      dist_valid <= echo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && echo_valid) begin
      distance <= dist_next;
    end
  end

endmodule

// ===== sv/mae_filter.sv =====
// Three-entry window, median, adaptive gain select, EMA update and result register.
module mae_filter (
  input  logic              clk,
  input  logic              rst,
  input  mae_pkg::mae_cfg_t cfg,
  input  logic              dist_valid,
  output logic              dist_ready,
  input  mae_pkg::dist_t    distance,
  mae_dist_if.source        result
);

  mae_pkg::dist_t window [3];
  mae_pkg::dist_t win_next [3];
  logic [1:0]     slot;
  logic [1:0]     slot_next;
  mae_pkg::dist_t smoothed;
  mae_pkg::dist_t smoothed_next;
  mae_pkg::dist_t med;
  mae_pkg::dist_t diff;
  mae_pkg::gain_t gain;
  logic [27:0]    blend;
  logic           out_en;
  logic           take;

  // Take a distance whenever the result register is free or drains
  assign out_en     = !result.valid || result.ready;
  assign dist_ready = out_en;
  assign take       = dist_valid && out_en;

  // Advance the ring slot and insert the new distance
  always_comb begin
    slot_next = (slot > 2'd1) ? 2'd0 : slot + 2'd1;
    for (int i = 0; i < 3; i++) begin
      win_next[i] = (slot_next == 2'(i)) ? distance : window[i];
    end
  end

  // Median, jump detect, gain pick and blend
  always_comb begin
    med  = mae_pkg::median3(win_next[0], win_next[1], win_next[2]);
    diff = (smoothed >= med) ? smoothed - med : med - smoothed;
    if (diff[17:8] > {2'b00, cfg.jump_limit_cm}) begin
      gain = mae_pkg::sat_gain(cfg.fast_gain);
    end else begin
      gain = mae_pkg::sat_gain(cfg.slow_gain);
    end
    blend = 28'(27'(med) * 27'(gain))
          + 28'(27'(smoothed) * 27'(mae_pkg::Q_ONE - gain));
    smoothed_next = blend[25:8];
  end

  // Update filter state on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      window[0] <= '0;
      window[1] <= '0;
      window[2] <= '0;
      slot      <= 2'd0;
      smoothed  <= '0;
    end else if (take) begin
      window[0] <= win_next[0];
      window[1] <= win_next[1];
      window[2] <= win_next[2];
      slot      <= slot_next;
      smoothed  <= smoothed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_en) begin
      result.valid <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.filtered_distance <= smoothed_next;
      result.median_distance   <= med;
    end
  end

endmodule

// ===== sv/median3_adaptive_ema_filter.sv =====
// Top level of the median-of-three adaptive EMA ultrasonic distance filter.
//
//   port      kind        carries
//   echo      sink        echo_time_us (15 b, microseconds, 0 = no echo)
//   result    source      filtered_distance, median_distance (18 b, cm Q.8)
//   cfg_*     write port  jump_limit_cm, fast_gain, slow_gain
//
// One item per cycle sustained while the result side is ready; each result passes the
// input register, loaded at the transfer, then conversion register, result register.
// The EMA and ring update are computed combinationally from the gain multiply and add.
// rst clears the window, slot, smoothed value and all valid flags, and restores
// the register defaults.
// Each stage holds under a stall and frees itself as soon as its successor drains.
module median3_adaptive_ema_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  mae_echo_if.sink   echo,
  mae_dist_if.source result
);

  mae_pkg::mae_cfg_t cfg;
  logic              conv_valid;
  logic              conv_ready;
  mae_pkg::dist_t    conv_dist;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_limit_cm <= mae_pkg::JUMP_LIMIT_RST;
      cfg.fast_gain     <= mae_pkg::FAST_GAIN_RST;
      cfg.slow_gain     <= mae_pkg::SLOW_GAIN_RST;
    end else if (cfg_we) begin
      unique case (mae_pkg::cfg_idx_e'(cfg_index))
        mae_pkg::CFG_JUMP_LIMIT: cfg.jump_limit_cm <= cfg_wdata[7:0];
        mae_pkg::CFG_FAST_GAIN:  cfg.fast_gain     <= cfg_wdata;
        mae_pkg::CFG_SLOW_GAIN:  cfg.slow_gain     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mae_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .echo       (echo),
    .dist_valid (conv_valid),
    .dist_ready (conv_ready),
    .distance   (conv_dist)
  );

  mae_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .dist_valid (conv_valid),
    .dist_ready (conv_ready),
    .distance   (conv_dist),
    .result     (result)
  );

endmodule

// ===== sv/mae_checker.sv =====
// Port-level checker for the median/EMA filter, bound to the top level.
`include "median3_adaptive_ema_filter_defines.svh"

module mae_checker (
  input logic           clk,
  input logic           rst,
  input logic           dist_valid,
  input logic           dist_ready,
  input mae_pkg::dist_t filtered_distance,
  input mae_pkg::dist_t median_distance
);

  // A stalled result holds its payload
  `MAE_ASSERT_NEXT(a_stall_hold, dist_valid && !dist_ready, dist_valid && $stable(filtered_distance) && $stable(median_distance), "stalled result changed")

  // No result straight out of reset
  `MAE_ASSERT_NOW(a_reset_empty, $past(rst), !dist_valid, "result valid right after reset")

  // Median never exceeds the range cutoff
  `MAE_ASSERT_NOW(a_median_range, dist_valid, median_distance[17:8] <= mae_pkg::MAX_RANGE_CM, "median beyond range")

  // The smoothed value, a blend of in-range medians, stays in range
  `MAE_ASSERT_NOW(a_filter_range, dist_valid, filtered_distance[17:8] <= mae_pkg::MAX_RANGE_CM, "filtered beyond range")

endmodule

bind median3_adaptive_ema_filter mae_checker u_mae_checker (
  .clk               (clk),
  .rst               (rst),
  .dist_valid        (result.valid),
  .dist_ready        (result.ready),
  .filtered_distance (result.filtered_distance),
  .median_distance   (result.median_distance)
);

// ===== tb/sv/median3_adaptive_ema_filter_tb.sv =====
// Self-checking testbench of the median-of-three adaptive EMA distance filter.
module median3_adaptive_ema_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mae_pkg::dist_t filtered;
    mae_pkg::dist_t median;
  } distance_pair_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  mae_echo_if echo_ch ();
  mae_dist_if dist_ch ();

  median3_adaptive_ema_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .echo      (echo_ch.sink),
    .result    (dist_ch.source)
  );

  // Stimulus and expectation stores
  mae_pkg::echo_t pending_echoes[$];
  distance_pair_t expected_distances[$];
  int unsigned    mismatch_count = 0;
  int unsigned    sender_idle_pct = 0;
  int unsigned    ready_stall_pct = 0;
  logic           echo_taken = 1'b0;

  // Predicted filter state and register copies
  mae_pkg::dist_t  window_cm[3];
  logic [1:0]      window_slot;
  mae_pkg::dist_t  smoothed_cm;
  mae_pkg::limit_t jump_limit;
  mae_pkg::gain_t  fast_gain;
  mae_pkg::gain_t  slow_gain;

  // Random walk of the simulated target distance
  int walk_cm = 100;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // keep the log short when everything goes wrong
    if (mismatch_count <= 50) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  // Advance the predicted state by one echo and return the expected result
  function automatic void filter_echo(input mae_pkg::echo_t echo,
                                      output mae_pkg::dist_t filtered,
                                      output mae_pkg::dist_t median);
    longint unsigned scaled;
    longint unsigned k;
    longint unsigned blend;
    mae_pkg::dist_t  d;
    mae_pkg::dist_t  lo;
    mae_pkg::dist_t  hi;
    mae_pkg::dist_t  med;
    mae_pkg::dist_t  diff;
    mae_pkg::gain_t  g;

    scaled = (64'(echo) * 64'(mae_pkg::CONV_MUL)) >> 10;
    d = scaled[17:0];
    // beyond range reads the same as no echo
    if ((d >> 8) > mae_pkg::MAX_RANGE_CM) begin
      d = '0;
    end

    // advance the slot before the write, wrapping after slot two
    if (window_slot > 2'd1) begin
      window_slot = 2'd0;
    end else begin
      window_slot = window_slot + 2'd1;
    end
    window_cm[window_slot] = d;

    // median is the third entry clamped between the other two
    lo = (window_cm[0] < window_cm[1]) ? window_cm[0] : window_cm[1];
    hi = (window_cm[0] < window_cm[1]) ? window_cm[1] : window_cm[0];
    med = (window_cm[2] < hi) ? window_cm[2] : hi;
    med = (med > lo) ? med : lo;

    diff = (smoothed_cm >= med) ? smoothed_cm - med : med - smoothed_cm;
    g = ((diff >> 8) > jump_limit) ? fast_gain : slow_gain;
    k = (g > mae_pkg::Q_ONE) ? 64'(mae_pkg::Q_ONE) : 64'(g);

    blend = (64'(med) * k + 64'(smoothed_cm) * (64'(mae_pkg::Q_ONE) - k)) >> 8;
    smoothed_cm = blend[17:0];

    filtered = smoothed_cm;
    median = med;
  endfunction

  // Track register writes, predict on input transfers, check output transfers
  always @(posedge clk) begin
    distance_pair_t want;
    mae_pkg::dist_t f;
    mae_pkg::dist_t m;

    if (rst) begin
      window_cm   = '{default: '0};
      window_slot = 2'd0;
      smoothed_cm = '0;
      jump_limit  = mae_pkg::JUMP_LIMIT_RST;
      fast_gain   = mae_pkg::FAST_GAIN_RST;
      slow_gain   = mae_pkg::SLOW_GAIN_RST;
      echo_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (mae_pkg::cfg_idx_e'(cfg_index))
          mae_pkg::CFG_JUMP_LIMIT: jump_limit = cfg_wdata[7:0];
          mae_pkg::CFG_FAST_GAIN:  fast_gain  = cfg_wdata;
          mae_pkg::CFG_SLOW_GAIN:  slow_gain  = cfg_wdata;
          default: ;
        endcase
      end

      if (dist_ch.valid && dist_ch.ready) begin
        if (expected_distances.size() == 0) begin
          report_mismatch($sformatf("unexpected result filtered=%0d median=%0d",
                                    dist_ch.filtered_distance, dist_ch.median_distance));
        end else begin
          want = expected_distances.pop_front();
          if (dist_ch.filtered_distance !== want.filtered) begin
            report_mismatch($sformatf("filtered_distance got %0d want %0d",
                                      dist_ch.filtered_distance, want.filtered));
          end
          if (dist_ch.median_distance !== want.median) begin
            report_mismatch($sformatf("median_distance got %0d want %0d",
                                      dist_ch.median_distance, want.median));
          end
        end
      end

      if (echo_ch.valid && echo_ch.ready) begin
        filter_echo(echo_ch.echo_time_us, f, m);
        want.filtered = f;
        want.median = m;
        expected_distances.push_back(want);
      end
      echo_taken <= echo_ch.valid && echo_ch.ready;
    end
  end

  // Feed echoes and stall the result side at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      echo_ch.valid <= 1'b0;
      dist_ch.ready <= 1'b0;
    end else begin
      dist_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
      if (!echo_ch.valid || echo_taken) begin
        if (pending_echoes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          echo_ch.valid <= 1'b1;
          echo_ch.echo_time_us <= pending_echoes.pop_front();
        end else begin
          echo_ch.valid <= 1'b0;
          echo_ch.echo_time_us <= mae_pkg::echo_t'($urandom);
        end
      end
    end
  end

  task automatic write_register(input mae_pkg::cfg_idx_e idx, input logic [8:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_settings(input logic [8:0] limit, input logic [8:0] fast,
                                input logic [8:0] slow);
    write_register(mae_pkg::CFG_JUMP_LIMIT, limit);
    write_register(mae_pkg::CFG_FAST_GAIN, fast);
    write_register(mae_pkg::CFG_SLOW_GAIN, slow);
  endtask

  // Hold until every queued echo is taken and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_echoes.size() != 0 || echo_ch.valid ||
               expected_distances.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  function automatic mae_pkg::echo_t echo_from_cm(input int cm);
    int e;
    e = cm * 115 / 2 + $urandom_range(0, 40) - 20;
    if (e < 0) begin
      e = 0;
    end else if (e > 32767) begin
      e = 32767;
    end
    return mae_pkg::echo_t'(e);
  endfunction

  // Mostly a plausible target walk, with spikes, dropouts and noise mixed in
  function automatic mae_pkg::echo_t next_sensor_echo();
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 8) begin
      walk_cm = $urandom_range(2, 400);
    end else begin
      walk_cm = walk_cm + $urandom_range(0, 6) - 3;
      if (walk_cm < 0) walk_cm = 0;
      if (walk_cm > 569) walk_cm = 569;
    end
    if (pick < 70) begin
      return echo_from_cm(walk_cm);
    end else if (pick < 78) begin
      return mae_pkg::echo_t'($urandom_range(0, 23057));
    end else if (pick < 83) begin
      return '0;
    end else if (pick < 88) begin
      return mae_pkg::echo_t'($urandom_range(23058, 32767));
    end
    return mae_pkg::echo_t'($urandom_range(0, 32767));
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_echoes.push_back(next_sensor_echo());
  endtask

  initial begin
    mae_pkg::echo_t directed[$];
    int             mode;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    echo_ch.valid = 1'b0;
    echo_ch.echo_time_us = '0;
    dist_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: no echo, field extremes, range edge, bit patterns, steady and jump
    directed = '{15'd0, 15'd57, 15'd58, 15'h7FFF, 15'd23057, 15'd23058, 15'd23057,
                 15'd1, 15'h2AAA, 15'h5555, 15'h7FFF, 15'd0, 15'd0,
                 15'd1150, 15'd1150, 15'd1150, 15'd1180, 15'd11500, 15'd11500,
                 15'd11500, 15'd11520, 15'h4000};
    foreach (directed[i]) pending_echoes.push_back(directed[i]);
    wait_idle();

    // Random phases under several settings and idle patterns
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_settings(9'd0, 9'd256, 9'd0);
        1: write_settings(9'h1FF, 9'd0, 9'h1FF);
        2: write_settings(9'd1, 9'd300, 9'd256);
        3: write_settings(9'd255, 9'd256, 9'd256);
        default: write_settings(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                9'($urandom_range(0, 300)));
      endcase
      mode = phase % 4;
      sender_idle_pct = (mode == 1) ? 54 : (mode == 3) ? 31 : 0;
      ready_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 31 : 0;
      if (phase == 5) begin
        // pause the sender mid-phase until all results are back
        queue_random(110);
        wait_idle();
        queue_random(110);
      end else begin
        queue_random(225);
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
